// ===== rtl/assert_macros.svh =====
// assertion macros shared by the stepper rtl
// no dependencies; included by the modules that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check sampled on the clock, suspended while reset is high
`define CHK_SYNC(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// check sampled on the clock, active during reset too
`define CHK_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`endif

// ===== rtl/udkr_pkg.sv =====
// shared types, codes and the event table of the up/down key stepper
// no dependencies
package udkr_pkg;

   localparam int COUNTER_WIDTH_DEF = 16;
   localparam int TOP_LEVEL_DEF     = 11;
   localparam int TICK_WIDTH        = 16;

   // action codes
   localparam logic [1:0] ACT_NONE = 2'd0;
   localparam logic [1:0] ACT_UP   = 2'd1;
   localparam logic [1:0] ACT_DOWN = 2'd2;
   localparam logic [1:0] ACT_HOLD = 2'd3;

   // button events
   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_BOTH    = 3'd1;
   localparam logic [2:0] EV_UP_EDGE = 3'd2;
   localparam logic [2:0] EV_DN_EDGE = 3'd3;
   localparam logic [2:0] EV_UP_HOLD = 3'd4;
   localparam logic [2:0] EV_DN_HOLD = 3'd5;

   // register indexes
   localparam logic [2:0] CSR_STEP_MIN     = 3'd0;
   localparam logic [2:0] CSR_STEP_MAX     = 3'd1;
   localparam logic [2:0] CSR_STEP_DEFAULT = 3'd2;
   localparam logic [2:0] CSR_STEP_INC     = 3'd3;
   localparam logic [2:0] CSR_LONG_PRESS   = 3'd4;
   localparam logic [2:0] CSR_REPEAT       = 3'd5;

   // register reset values
   localparam logic [7:0]            STEP_MIN_RST     = 8'd1;
   localparam logic [7:0]            STEP_MAX_RST     = 8'd11;
   localparam logic [7:0]            STEP_DEFAULT_RST = 8'd6;
   localparam logic [7:0]            STEP_INC_RST     = 8'd1;
   localparam logic [TICK_WIDTH-1:0] LONG_PRESS_RST   = 16'd50;
   localparam logic [TICK_WIDTH-1:0] REPEAT_RST       = 16'd24;

   typedef struct packed {
      logic       judge_enable;
      logic       up_pressed;
      logic       down_pressed;
      logic [7:0] stored_step;
      logic       store_accepts;
   } req_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] current_step;
      logic [7:0] display_level;
      logic       write_request;
      logic [7:0] write_value;
   } rsp_type;

   typedef struct packed {
      logic [7:0]            step_min;
      logic [7:0]            step_max;
      logic [7:0]            step_default;
      logic [7:0]            step_increment;
      logic [TICK_WIDTH-1:0] long_press_ticks;
      logic [TICK_WIDTH-1:0] repeat_ticks;
   } cfg_type;

   // history bits: 0 up now, 1 up before, 2 down now, 3 down before
   function automatic logic [2:0] classify(input logic [3:0] hist);
      logic [2:0] ev;
      unique case (hist)
         4'h0, 4'h2, 4'h8, 4'hA: ev = EV_NONE;
         4'h1, 4'h9:             ev = EV_UP_EDGE;
         4'h3, 4'hB:             ev = EV_UP_HOLD;
         4'h4, 4'h6:             ev = EV_DN_EDGE;
         4'hC, 4'hE:             ev = EV_DN_HOLD;
         4'h5, 4'h7, 4'hD, 4'hF: ev = EV_BOTH;
         default:                ev = EV_NONE;
      endcase
      return ev;
   endfunction

endpackage

// ===== rtl/udkr_action.sv =====
// button history, event decode and the two hold counters
// depends on udkr_pkg and assert_macros.svh
`include "assert_macros.svh"

module udkr_action #(
   parameter int COUNTER_WIDTH = udkr_pkg::COUNTER_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  udkr_pkg::req_type item,
   input  udkr_pkg::cfg_type cfg,
   output logic [1:0]        action
);
   import udkr_pkg::*;

   localparam int CMP_WIDTH = (COUNTER_WIDTH > TICK_WIDTH) ? COUNTER_WIDTH : TICK_WIDTH;
   localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

   logic [3:0]               hist_ff, hist_in;
   logic [COUNTER_WIDTH-1:0] up_cnt_ff, up_cnt_in;
   logic [COUNTER_WIDTH-1:0] dn_cnt_ff, dn_cnt_in;
   logic [COUNTER_WIDTH-1:0] up_inc, dn_inc, reload;
   logic [TICK_WIDTH-1:0]    reload_raw;
   logic [CMP_WIDTH-1:0]     long_ext, up_ext, dn_ext, reload_ext, max_ext;
   logic [2:0]               ev;

   assign hist_in = item.judge_enable
      ? {hist_ff[2], item.down_pressed, hist_ff[0], item.up_pressed} : 4'h0;
   assign ev = item.judge_enable ? classify(hist_in) : EV_NONE;

   assign up_inc = (up_cnt_ff != CNT_MAX) ? up_cnt_ff + 1'b1 : up_cnt_ff;
   assign dn_inc = (dn_cnt_ff != CNT_MAX) ? dn_cnt_ff + 1'b1 : dn_cnt_ff;

   assign reload_raw = (cfg.repeat_ticks <= cfg.long_press_ticks)
      ? cfg.long_press_ticks - cfg.repeat_ticks : '0;
   assign reload_ext = CMP_WIDTH'(reload_raw);
   assign max_ext    = CMP_WIDTH'(CNT_MAX);
   assign reload     = (reload_ext > max_ext) ? CNT_MAX : reload_ext[COUNTER_WIDTH-1:0];
   assign long_ext   = CMP_WIDTH'(cfg.long_press_ticks);
   assign up_ext     = CMP_WIDTH'(up_inc);
   assign dn_ext     = CMP_WIDTH'(dn_inc);

   always_comb begin
      action    = ACT_NONE;
      up_cnt_in = CNT_MAX;
      dn_cnt_in = CNT_MAX;
      unique case (ev)
         EV_BOTH, EV_UP_EDGE, EV_DN_EDGE: begin
            action    = (ev == EV_BOTH) ? ACT_HOLD : (ev == EV_UP_EDGE) ? ACT_UP : ACT_DOWN;
            up_cnt_in = '0;
            dn_cnt_in = '0;
         end
         EV_UP_HOLD: begin
            action    = ACT_HOLD;
            up_cnt_in = up_inc;
            dn_cnt_in = '0;
            if (up_ext >= long_ext) begin
               action    = ACT_UP;
               up_cnt_in = reload;
            end
         end
         EV_DN_HOLD: begin
            action    = ACT_HOLD;
            dn_cnt_in = dn_inc;
            up_cnt_in = '0;
            if (dn_ext >= long_ext) begin
               action    = ACT_DOWN;
               dn_cnt_in = reload;
            end
         end
         default: begin
            action    = ACT_NONE;
            up_cnt_in = CNT_MAX;
            dn_cnt_in = CNT_MAX;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff   <= 4'h0;
         up_cnt_ff <= CNT_MAX;
         dn_cnt_ff <= CNT_MAX;
      end else if (advance) begin
         hist_ff   <= hist_in;
         up_cnt_ff <= up_cnt_in;
         dn_cnt_ff <= dn_cnt_in;
      end
   end

   `CHK_SYNC(a_disable_saturates, clock, reset,
      advance && !item.judge_enable |=> up_cnt_ff == CNT_MAX && dn_cnt_ff == CNT_MAX)
   `CHK_SYNC(a_one_counter_runs, clock, reset,
      advance && (ev == EV_UP_HOLD || ev == EV_DN_HOLD) |=> up_cnt_ff == '0 || dn_cnt_ff == '0)
   `CHK_ALWAYS(a_reset_state, clock,
      reset |=> hist_ff == 4'h0 && up_cnt_ff == CNT_MAX)

endmodule

// ===== rtl/udkr_step.sv =====
// step register, saturating step update, storage write and display level
// depends on udkr_pkg and assert_macros.svh
`include "assert_macros.svh"

module udkr_step #(
   parameter int TOP_LEVEL = udkr_pkg::TOP_LEVEL_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [1:0]        action,
   input  udkr_pkg::req_type item,
   input  udkr_pkg::cfg_type cfg,
   output udkr_pkg::rsp_type result
);
   import udkr_pkg::*;

   localparam logic [7:0] TOP = 8'(TOP_LEVEL);

   logic [7:0] step_ff, step_in;
   logic [7:0] base, next, shown;
   logic [8:0] up_sum, dn_floor;
   logic       wreq;

   assign base     = (cfg.step_min <= item.stored_step && item.stored_step <= cfg.step_max)
      ? item.stored_step : step_ff;
   assign up_sum   = {1'b0, base} + {1'b0, cfg.step_increment};
   assign dn_floor = {1'b0, cfg.step_min} + {1'b0, cfg.step_increment};

   always_comb begin
      next = base;
      if (action == ACT_UP) begin
         next = (up_sum <= {1'b0, cfg.step_max}) ? up_sum[7:0] : cfg.step_max;
      end else if (action == ACT_DOWN) begin
         next = ({1'b0, base} >= dn_floor) ? base - cfg.step_increment : cfg.step_min;
      end
   end

   assign wreq    = (action == ACT_UP || action == ACT_DOWN) && next != base;
   assign step_in = (wreq && item.store_accepts) ? next : base;
   assign shown   = (cfg.step_min <= step_in && step_in <= cfg.step_max)
      ? step_in : cfg.step_default;

   assign result.action        = action;
   assign result.current_step  = step_in;
   assign result.display_level = (shown <= TOP) ? TOP - shown : 8'd0;
   assign result.write_request = wreq;
   assign result.write_value   = wreq ? next : 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_DEFAULT_RST;
      end else if (advance) begin
         step_ff <= step_in;
      end
   end

   `CHK_SYNC(a_write_only_on_step, clock, reset,
      wreq |-> action == ACT_UP || action == ACT_DOWN)
   `CHK_SYNC(a_accepted_write_kept, clock, reset,
      advance && wreq && item.store_accepts |=> step_ff == $past(next))

endmodule

// ===== rtl/updown_key_repeat_level_stepper.sv =====
// top level of the up/down key auto-repeat stepper: handshake, config regs
// depends on udkr_pkg, udkr_action, udkr_step and assert_macros.svh
// a word accepted goes to the input register, then to the result register once that is free
// throughput: one word per cycle while the result side does not stall
// reset (synchronous, active high) restores register defaults, clears history,
// saturates both hold counters and loads the step with the default step
`include "assert_macros.svh"

module updown_key_repeat_level_stepper #(
   parameter int COUNTER_WIDTH = udkr_pkg::COUNTER_WIDTH_DEF,
   parameter int TOP_LEVEL     = udkr_pkg::TOP_LEVEL_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // tick words in
   input  logic              req_valid,
   output logic              req_stall,
   input  udkr_pkg::req_type req_data,
   // result words out
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output udkr_pkg::rsp_type rsp_data,
   // register writes
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_data
);
   import udkr_pkg::*;

   // configuration registers
   cfg_type cfg_ff;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_ff;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   logic       fire;
   logic [1:0] action;
   rsp_type    result;

   // the tick in the input register is processed when the result register frees up
   assign fire      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign csr_ready = 1'b1;

   assign in_valid_in  = (req_valid && !req_stall) ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : ((rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   // register file, writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_min         <= STEP_MIN_RST;
         cfg_ff.step_max         <= STEP_MAX_RST;
         cfg_ff.step_default     <= STEP_DEFAULT_RST;
         cfg_ff.step_increment   <= STEP_INC_RST;
         cfg_ff.long_press_ticks <= LONG_PRESS_RST;
         cfg_ff.repeat_ticks     <= REPEAT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_STEP_MIN:     cfg_ff.step_min         <= csr_data[7:0];
            CSR_STEP_MAX:     cfg_ff.step_max         <= csr_data[7:0];
            CSR_STEP_DEFAULT: cfg_ff.step_default     <= csr_data[7:0];
            CSR_STEP_INC:     cfg_ff.step_increment   <= csr_data[7:0];
            CSR_LONG_PRESS:   cfg_ff.long_press_ticks <= csr_data;
            CSR_REPEAT:       cfg_ff.repeat_ticks     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // event decode and hold counters
   udkr_action #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_action (
      .clock  (clock),
      .reset  (reset),
      .advance(fire),
      .item   (in_ff),
      .cfg    (cfg_ff),
      .action (action)
   );

   // step update and display level
   udkr_step #(
      .TOP_LEVEL(TOP_LEVEL)
   ) u_step (
      .clock  (clock),
      .reset  (reset),
      .advance(fire),
      .action (action),
      .item   (in_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CHK_SYNC(a_stall_needs_item, clock, reset,
      req_stall |-> in_valid_ff && rsp_valid_ff && rsp_stall)
   `CHK_SYNC(a_fire_fills_result, clock, reset,
      fire |=> rsp_valid_ff)
   `CHK_ALWAYS(a_reset_empties, clock,
      reset |=> !in_valid_ff && !rsp_valid_ff)

endmodule

// ===== dv/tb.sv =====
// self-checking bench for the up/down key auto-repeat stepper
// depends on udkr_pkg and the stepper rtl; a directed table first, then random press traffic
// an in-bench model of the stepper predicts each result word that a directed row does not pin
module tb;
   import udkr_pkg::*;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int PHASE_TICKS     = 225;
   localparam int PHASE_COUNT     = 8;

   localparam logic [COUNTER_WIDTH_DEF-1:0] HOLD_SAT = '1;

   typedef enum bit {ROW_TICK, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [2:0]   idx;
      logic [15:0]  val;
      req_type      w;
      bit           pin;
      rsp_type      want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   // typed expectation riding along with the current tick word
   bit          pin_on;
   rsp_type     pin_want;

   // stepper model state and its copy of the registers
   cfg_type                      live_cfg;
   logic [3:0]                   hist;
   logic [COUNTER_WIDTH_DEF-1:0] up_cnt;
   logic [COUNTER_WIDTH_DEF-1:0] dn_cnt;
   logic [7:0]                   step_now;

   rsp_type     tick_results_q[$];
   dir_row_type dir_rows[$];
   int          mismatches;
   int          cycle_count;
   int          ticks_sent;
   bit          hold_off_req;
   bit          tx_quiet;

   always #5 clock = ~clock;

   updown_key_repeat_level_stepper u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   function automatic bit fits(input int s);
      return live_cfg.step_min <= s && s <= live_cfg.step_max;
   endfunction

   // one tick of the stepper: history, hold counters, saturated step, display level
   function automatic rsp_type judge_tick(input req_type w);
      logic [2:0]                   ev;
      logic [1:0]                   act;
      logic [COUNTER_WIDTH_DEF-1:0] reload;
      int                           base;
      int                           nxt;
      int                           shown;
      rsp_type                      r;
      ev = EV_NONE;
      if (w.judge_enable) begin
         // old "now" bits move to "before", fresh levels land in "now"
         hist = {hist[2], w.down_pressed, hist[0], w.up_pressed};
         if (hist[0] && hist[2])
            ev = EV_BOTH;
         else if (hist[0])
            ev = hist[1] ? EV_UP_HOLD : EV_UP_EDGE;
         else if (hist[2])
            ev = hist[3] ? EV_DN_HOLD : EV_DN_EDGE;
      end else begin
         hist = 4'h0;
      end
      if (up_cnt != HOLD_SAT) up_cnt++;
      if (dn_cnt != HOLD_SAT) dn_cnt++;
      // repeat longer than the long press reloads to zero
      reload = (live_cfg.repeat_ticks <= live_cfg.long_press_ticks) ?
               live_cfg.long_press_ticks - live_cfg.repeat_ticks : '0;
      case (ev)
         EV_BOTH, EV_UP_EDGE, EV_DN_EDGE: begin
            act = (ev == EV_BOTH) ? ACT_HOLD : (ev == EV_UP_EDGE) ? ACT_UP : ACT_DOWN;
            up_cnt = '0;
            dn_cnt = '0;
         end
         EV_UP_HOLD: begin
            act = ACT_HOLD;
            if (up_cnt >= live_cfg.long_press_ticks) begin
               up_cnt = reload;
               act    = ACT_UP;
            end
            dn_cnt = '0;
         end
         EV_DN_HOLD: begin
            act = ACT_HOLD;
            if (dn_cnt >= live_cfg.long_press_ticks) begin
               dn_cnt = reload;
               act    = ACT_DOWN;
            end
            up_cnt = '0;
         end
         default: begin
            act    = ACT_NONE;
            up_cnt = HOLD_SAT;
            dn_cnt = HOLD_SAT;
         end
      endcase
      base = fits(w.stored_step) ? w.stored_step : step_now;
      nxt  = base;
      if (act == ACT_UP)
         nxt = (base + live_cfg.step_increment <= live_cfg.step_max) ?
               base + live_cfg.step_increment : live_cfg.step_max;
      else if (act == ACT_DOWN)
         nxt = (base >= live_cfg.step_min + live_cfg.step_increment) ?
               base - live_cfg.step_increment : live_cfg.step_min;
      r = '0;
      r.action = act;
      if ((act == ACT_UP || act == ACT_DOWN) && nxt != base) begin
         r.write_request = 1'b1;
         r.write_value   = nxt[7:0];
      end
      step_now = (r.write_request && w.store_accepts) ? nxt[7:0] : base[7:0];
      shown = fits(step_now) ? step_now : live_cfg.step_default;
      r.current_step  = step_now;
      r.display_level = (shown <= TOP_LEVEL_DEF) ? 8'(TOP_LEVEL_DEF - shown) : 8'd0;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // compare first, then book the newly accepted tick
   always @(posedge clock) begin
      rsp_type want;
      rsp_type pred;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (tick_results_q.size() == 0) begin
               $display("%0t: result word with nothing pending, got %h", $time, rsp_data);
               mismatches++;
            end else begin
               want = tick_results_q.pop_front();
               check_field("action",        want.action,        rsp_data.action);
               check_field("current_step",  want.current_step,  rsp_data.current_step);
               check_field("display_level", want.display_level, rsp_data.display_level);
               check_field("write_request", want.write_request, rsp_data.write_request);
               check_field("write_value",   want.write_value,   rsp_data.write_value);
            end
         end
         if (req_valid && !req_stall) begin
            pred = judge_tick(req_data);
            tick_results_q.push_back(pin_on ? pin_want : pred);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side back-pressure: short stalls mostly, a few long ones, quiet stretches,
   // and one long hold-off on request so the block backs up into its input
   initial begin
      int stall_left;
      int quiet_left;
      bit rx_quiet;
      stall_left = 0;
      quiet_left = 0;
      rx_quiet   = 1'b0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end else begin
            if (quiet_left == 0) begin
               rx_quiet   = ($urandom_range(0, 3) == 0);
               quiet_left = $urandom_range(50, 300);
            end
            quiet_left--;
            if (stall_left > 0) begin
               rsp_stall <= 1'b1;
               stall_left--;
            end else begin
               rsp_stall <= 1'b0;
               if (!rx_quiet && $urandom_range(0, 99) < 25)
                  stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
            end
         end
      end
   end

   // sender idle gap; none while the receiver is holding off so the block fills
   function automatic int tx_gap();
      int r;
      r = $urandom_range(0, 99);
      if (hold_off_req || tx_quiet || r < 70)
         return 0;
      return (r < 94) ? $urandom_range(1, 3) : $urandom_range(8, 40);
   endfunction

   task automatic send_word(input req_type w, input bit pin, input rsp_type want);
      int gap;
      gap = tx_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_data  <= req_type'($urandom);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= w;
      pin_on    <= pin;
      pin_want  <= want;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid and wait until every booked result has come back
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tick_results_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_STEP_MIN:     live_cfg.step_min         = val[7:0];
         CSR_STEP_MAX:     live_cfg.step_max         = val[7:0];
         CSR_STEP_DEFAULT: live_cfg.step_default     = val[7:0];
         CSR_STEP_INC:     live_cfg.step_increment   = val[7:0];
         CSR_LONG_PRESS:   live_cfg.long_press_ticks = val;
         CSR_REPEAT:       live_cfg.repeat_ticks     = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // 8-bit registers get junk in the upper byte, which the block drops
   task automatic apply_setting(input cfg_type c);
      settle();
      write_reg(CSR_STEP_MIN,     {8'($urandom), c.step_min});
      write_reg(CSR_STEP_MAX,     {8'($urandom), c.step_max});
      write_reg(CSR_STEP_DEFAULT, {8'($urandom), c.step_default});
      write_reg(CSR_STEP_INC,     {8'($urandom), c.step_increment});
      write_reg(CSR_LONG_PRESS,   c.long_press_ticks);
      write_reg(CSR_REPEAT,       c.repeat_ticks);
   endtask

   // storage read-back: mostly outside the window so the step carries over
   function automatic logic [7:0] pick_stored();
      int lo;
      int hi;
      int r;
      lo = live_cfg.step_min;
      hi = live_cfg.step_max;
      r  = $urandom_range(0, 9);
      if (r < 5 && lo > 0)
         return 8'($urandom_range(0, lo - 1));
      if (r < 5 && hi < 255)
         return 8'($urandom_range(hi + 1, 255));
      if (r < 8 && lo <= hi)
         return 8'($urandom_range(lo, hi));
      return 8'($urandom);
   endfunction

   task automatic push_tick(input bit en, input bit up, input bit dn);
      req_type w;
      w.judge_enable  = en;
      w.up_pressed    = up;
      w.down_pressed  = dn;
      w.stored_step   = pick_stored();
      w.store_accepts = ($urandom_range(0, 7) != 0);
      send_word(w, 1'b0, '0);
      ticks_sent++;
   endtask

   function automatic dir_row_type tick_row(input bit en, input bit up, input bit dn,
                                            input logic [7:0] stored, input bit acc,
                                            input bit pin, input rsp_type want);
      dir_row_type row;
      row.kind = ROW_TICK;
      row.idx  = '0;
      row.val  = '0;
      row.w    = '{en, up, dn, stored, acc};
      row.pin  = pin;
      row.want = want;
      return row;
   endfunction

   function automatic dir_row_type csr_row(input logic [2:0] idx, input logic [15:0] val);
      dir_row_type row;
      row.kind = ROW_CSR;
      row.idx  = idx;
      row.val  = val;
      row.w    = '0;
      row.pin  = 1'b0;
      row.want = '0;
      return row;
   endfunction

   initial begin
      cfg_type plan[PHASE_COUNT];
      int      p;
      int      i;
      int      r;
      int      len;
      int      lp;
      int      rp;
      bit      up;
      bit      dn;
      bit      held;
      bit      paused;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      pin_on      = 1'b0;
      pin_want    = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      mismatches  = 0;
      cycle_count = 0;
      ticks_sent  = 0;
      hold_off_req = 1'b0;
      tx_quiet    = 1'b0;
      held        = 1'b0;
      paused      = 1'b0;

      live_cfg = '{STEP_MIN_RST, STEP_MAX_RST, STEP_DEFAULT_RST, STEP_INC_RST,
                   LONG_PRESS_RST, REPEAT_RST};
      hist     = 4'h0;
      up_cnt   = HOLD_SAT;
      dn_cnt   = HOLD_SAT;
      step_now = STEP_DEFAULT_RST;

      // directed rows at reset settings (min 1, max 11, default 6, increment 1)
      // judging off after reset: default step shown
      dir_rows.push_back(tick_row(0, 0, 0, 8'd0,   1, 1, '{ACT_NONE, 8'd6, 8'd5, 1'b0, 8'd0}));
      // up press edge steps at once
      dir_rows.push_back(tick_row(1, 1, 0, 8'd0,   1, 1, '{ACT_UP,   8'd7, 8'd4, 1'b1, 8'd7}));
      // held, long press not reached yet
      dir_rows.push_back(tick_row(1, 1, 0, 8'd0,   1, 1, '{ACT_HOLD, 8'd7, 8'd4, 1'b0, 8'd0}));
      // down edge, storage refuses the write so the step stays
      dir_rows.push_back(tick_row(1, 0, 1, 8'd0,   0, 1, '{ACT_DOWN, 8'd7, 8'd4, 1'b1, 8'd6}));
      // both buttons
      dir_rows.push_back(tick_row(1, 1, 1, 8'd0,   1, 1, '{ACT_HOLD, 8'd7, 8'd4, 1'b0, 8'd0}));
      // in-range stored step overrides
      dir_rows.push_back(tick_row(0, 0, 0, 8'd3,   1, 1, '{ACT_NONE, 8'd3, 8'd8, 1'b0, 8'd0}));
      // up at the top saturates, nothing to write
      dir_rows.push_back(tick_row(1, 1, 0, 8'd11,  1, 1, '{ACT_UP,   8'd11, 8'd0, 1'b0, 8'd0}));
      // down at the bottom saturates
      dir_rows.push_back(tick_row(1, 0, 1, 8'd1,   1, 1, '{ACT_DOWN, 8'd1, 8'd10, 1'b0, 8'd0}));
      // buttons ignored when judging is off
      dir_rows.push_back(tick_row(0, 1, 1, 8'd255, 1, 1, '{ACT_NONE, 8'd1, 8'd10, 1'b0, 8'd0}));
      // short long-press so a hold auto-repeats
      dir_rows.push_back(csr_row(CSR_LONG_PRESS, 16'd3));
      dir_rows.push_back(csr_row(CSR_REPEAT,     16'd1));
      for (i = 0; i < 5; i++)
         dir_rows.push_back(tick_row(1, 1, 0, 8'd0, 1, 0, '0));
      // huge increment: both directions clamp without wrapping
      dir_rows.push_back(csr_row(CSR_STEP_INC, 16'd255));
      dir_rows.push_back(tick_row(1, 0, 1, 8'd0, 1, 0, '0));
      dir_rows.push_back(tick_row(1, 1, 0, 8'd0, 1, 0, '0));
      // inverted window: nothing is in range
      dir_rows.push_back(csr_row(CSR_STEP_MIN, 16'd20));
      dir_rows.push_back(csr_row(CSR_STEP_MAX, 16'd5));
      dir_rows.push_back(tick_row(1, 1, 0, 8'd7, 1, 0, '0));
      dir_rows.push_back(tick_row(0, 0, 0, 8'd0, 1, 0, '0));

      // random phases, extremes included
      plan[0] = '{8'd1,   8'd11,  8'd6,   8'd1,   16'd5,     16'd2};
      plan[1] = '{8'd0,   8'd255, 8'd0,   8'd255, 16'd0,     16'd0};
      plan[2] = '{8'd255, 8'd0,   8'd255, 8'd1,   16'd3,     16'd7};
      plan[3] = '{8'd3,   8'd9,   8'd200, 8'd2,   16'd8,     16'd3};
      plan[4] = '{8'd0,   8'd20,  8'd12,  8'd3,   16'd65534, 16'd65534};
      plan[7] = '{8'd1,   8'd11,  8'd6,   8'd1,   16'd50,    16'd24};

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[k]) begin
         if (dir_rows[k].kind == ROW_CSR) begin
            settle();
            write_reg(dir_rows[k].idx, dir_rows[k].val);
         end else begin
            send_word(dir_rows[k].w, dir_rows[k].pin, dir_rows[k].want);
         end
      end

      for (p = 0; p < PHASE_COUNT; p++) begin
         if (p == 5 || p == 6) begin
            // random window; phase 6 lets min and max land anywhere
            plan[p].step_min     = (p == 5) ? 8'($urandom_range(0, 30)) : 8'($urandom);
            plan[p].step_max     = (p == 5) ? 8'(plan[p].step_min + $urandom_range(0, 40))
                                            : 8'($urandom);
            plan[p].step_default = 8'($urandom);
            plan[p].step_increment = 8'($urandom_range(1, (p == 5) ? 6 : 255));
            plan[p].long_press_ticks = 16'($urandom_range(0, 12));
            plan[p].repeat_ticks     = 16'($urandom_range(0, 14));
         end
         apply_setting(plan[p]);
         ticks_sent = 0;
         while (ticks_sent < PHASE_TICKS) begin
            // receiver holds off once while the sender keeps offering
            if (p == 0 && !held && ticks_sent >= 60) begin
               hold_off_req = 1'b1;
               held = 1'b1;
            end
            // sender waits once for every result mid-phase
            if (p == 2 && !paused && ticks_sent >= 100) begin
               settle();
               paused = 1'b1;
            end
            tx_quiet = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 75) begin
               // release, then a press held for a random length, often long enough to auto-repeat
               len = $urandom_range(0, 3);
               for (i = 0; i < len; i++) push_tick(1'b1, 1'b0, 1'b0);
               r  = $urandom_range(0, 9);
               up = (r < 5) || (r == 9);
               dn = (r >= 5);
               lp = live_cfg.long_press_ticks;
               rp = (live_cfg.repeat_ticks > 16) ? 16 : live_cfg.repeat_ticks;
               len = (lp <= 16) ? $urandom_range(1, 3 * lp + rp + 3) : $urandom_range(1, 30);
               for (i = 0; i < len; i++)
                  push_tick(($urandom_range(0, 19) != 0), up, dn);
            end else if (r < 90) begin
               // button chatter
               len = $urandom_range(1, 8);
               for (i = 0; i < len; i++)
                  push_tick(($urandom_range(0, 3) != 0), $urandom_range(0, 1),
                            $urandom_range(0, 1));
            end else begin
               // judging switched off
               len = $urandom_range(1, 5);
               for (i = 0; i < len; i++)
                  push_tick(1'b0, $urandom_range(0, 1), $urandom_range(0, 1));
            end
         end
      end

      settle();
      repeat (6) @(posedge clock);
      if (mismatches == 0 && tick_results_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/udkr_pkg.sv
rtl/udkr_action.sv
rtl/udkr_step.sv
rtl/updown_key_repeat_level_stepper.sv
dv/tb.sv
